// File: hw/rtl/learning_switch_forward_core_assert.svh
// Assertion macros for the learning switch forwarding core.
// Expects clk and arst_n in the scope of each use.
`ifndef LEARNING_SWITCH_FORWARD_CORE_ASSERT_SVH
`define LEARNING_SWITCH_FORWARD_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle brings another in the next.
`define LSF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/lsf_pkg.sv
// Shared types and constants for the learning switch forwarding core.
// No dependencies.
`default_nettype none

package lsf_pkg;

	localparam int MAC_W      = 48;
	localparam int ETYPE_W    = 16;
	localparam int IN_PORT_W  = 8;
	localparam int OUT_PORT_W = 8;
	localparam int CLASS_W    = 2;
	localparam int COUNT_W    = 32;
	localparam int GROUP_BIT  = 40;

	localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
	localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;

	localparam logic [CLASS_W-1:0] CLS_ARP   = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_IPV4  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_OTHER = 2'd2;
	localparam int NUM_CLASSES = 3;

	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_PORT_BITS     = 8;

	typedef struct packed {
		logic [MAC_W-1:0]     dest_mac;
		logic [MAC_W-1:0]     source_mac;
		logic [IN_PORT_W-1:0] ingress_port;
		logic                 learn;
		logic                 lookup;
		logic [CLASS_W-1:0]   frame_class;
		logic [COUNT_W-1:0]   class_count;
	} item_t;

	typedef struct packed {
		logic                  flood;
		logic [OUT_PORT_W-1:0] egress_port;
		logic [CLASS_W-1:0]    frame_class;
		logic [COUNT_W-1:0]    class_count;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/learning_switch_forward_core.sv
// Learning switch forwarding core: top level joining front end, queue and table engine.
// Depends on lsf_pkg, lsf_front, lsf_fifo, lsf_back and lsf_ram.
//
// Input channel: a frame header (dest_mac, source_mac, ether_type, ingress_port) is
// taken at a rising edge where start is high and busy is low. Up to two headers wait
// in the request queue while the table engine works; busy rises when it is full.
// Output channel: one result per header, in order, shown for one cycle with done high
// (flood, egress_port, frame_class, class_count). The receiver cannot stall.
// Sequence: the table engine pops a header when idle, scans, drains the last read,
// then learns, and done follows; headers that need no table access, or an empty table,
// skip scan and drain. It takes no new header until it is through with the last. The
// scan reads the first entries_used (learned) MAC entries through the table's single
// read port (one entry a cycle) and compares each against both source and dest MAC at once.
// Reset: arst_n clears the class counters, the fill count and the queue; table
// contents need no clearing, as only the first entries_used slots are ever read.
`default_nettype none

module learning_switch_forward_core import lsf_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int PORT_BITS     = DEF_PORT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [MAC_W-1:0]      dest_mac,
	input  wire logic [MAC_W-1:0]      source_mac,
	input  wire logic [ETYPE_W-1:0]    ether_type,
	input  wire logic [IN_PORT_W-1:0]  ingress_port,
	output logic                       done,
	output logic                       flood,
	output logic      [OUT_PORT_W-1:0] egress_port,
	output logic      [CLASS_W-1:0]    frame_class,
	output logic      [COUNT_W-1:0]    class_count
);

	logic    push;
	logic    full;
	logic    empty;
	logic    pop;
	item_t   push_item;
	item_t   head;
	result_t result;

	assign busy = full;

	lsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.full        (full),
		.dest_mac    (dest_mac),
		.source_mac  (source_mac),
		.ether_type  (ether_type),
		.ingress_port(ingress_port),
		.push        (push),
		.item        (push_item)
	);

	lsf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	lsf_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.PORT_BITS    (PORT_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.head  (head),
		.pop   (pop),
		.done  (done),
		.result(result)
	);

	assign flood       = result.flood;
	assign egress_port = result.egress_port;
	assign frame_class = result.frame_class;
	assign class_count = result.class_count;

endmodule

`default_nettype wire

// File: hw/rtl/lsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsf_front.sv
// Front end: accepts frame headers, classifies the EtherType and counts per class.
// Depends on lsf_pkg.
`default_nettype none

module lsf_front import lsf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 full,
	input  wire logic [MAC_W-1:0]     dest_mac,
	input  wire logic [MAC_W-1:0]     source_mac,
	input  wire logic [ETYPE_W-1:0]   ether_type,
	input  wire logic [IN_PORT_W-1:0] ingress_port,
	output logic                      push,
	output item_t                     item
);

	logic [COUNT_W-1:0] ctr_q [NUM_CLASSES];
	logic [CLASS_W-1:0] cls;
	logic [COUNT_W-1:0] ctr_next;

	always_comb begin
		unique case (ether_type)
			ETYPE_ARP:  cls = CLS_ARP;
			ETYPE_IPV4: cls = CLS_IPV4;
			default:    cls = CLS_OTHER;
		endcase
	end

	assign ctr_next = ctr_q[cls] + 1'b1;
	assign push     = start & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				ctr_q[i] <= '0;
			end
		end else if (push) begin
			ctr_q[cls] <= ctr_next;
		end
	end

	always_comb begin
		item.dest_mac     = dest_mac;
		item.source_mac   = source_mac;
		item.ingress_port = ingress_port;
		item.learn        = ~source_mac[GROUP_BIT];
		item.lookup       = ~dest_mac[GROUP_BIT];
		item.frame_class  = cls;
		item.class_count  = ctr_next;
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsf_fifo.sv
// Short request queue between the front end and the table engine.
// Depends on lsf_pkg.
`default_nettype none

module lsf_fifo import lsf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output logic       full,
	output logic       empty,
	output item_t      head
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lsf_back.sv
// Table engine: scans the MAC table, learns the source and resolves the destination.
// Depends on lsf_pkg, lsf_ram and the assertion macro header.
`default_nettype none
`include "learning_switch_forward_core_assert.svh"

module lsf_back import lsf_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int PORT_BITS     = DEF_PORT_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  empty,
	input  wire item_t head,
	output logic       pop,
	output logic       done,
	output result_t    result
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ENT_W = MAC_W + PORT_BITS;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_LEARN = 2'd3;

	logic [1:0]           state_q;
	item_t                cur_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     used_q;
	logic                 rd_valid_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 src_hit_q;
	logic [IDX_W-1:0]     src_slot_q;
	logic                 dst_hit_q;
	logic [PORT_BITS-1:0] dst_port_q;
	logic                 done_q;
	result_t              res_q;

	logic                 re;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [ENT_W-1:0]     wdata;
	logic [ENT_W-1:0]     rdata;
	logic [MAC_W-1:0]     ent_mac;
	logic [PORT_BITS-1:0] ent_port;
	logic [PORT_BITS-1:0] port_in;
	logic [PORT_BITS-1:0] port_out;
	logic                 last_issue;
	logic                 room;
	logic                 learned;
	logic                 self_hit;
	logic                 hit;
	result_t              res_next;

	lsf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign ent_mac    = rdata[ENT_W-1:PORT_BITS];
	assign ent_port   = rdata[PORT_BITS-1:0];
	assign re         = (state_q == S_SCAN);
	assign last_issue = ((CNT_W'(idx_q) + 1'b1) == used_q);
	assign pop        = (state_q == S_IDLE) && !empty;

	assign port_in  = PORT_BITS'(cur_q.ingress_port);
	assign room     = (used_q < CNT_W'(TABLE_ENTRIES));
	assign learned  = cur_q.learn && (src_hit_q || room);
	assign self_hit = learned && cur_q.lookup && (cur_q.dest_mac == cur_q.source_mac);
	assign hit      = cur_q.lookup && (self_hit || dst_hit_q);
	assign port_out = self_hit ? port_in : dst_port_q;

	assign we    = (state_q == S_LEARN) && learned;
	assign waddr = src_hit_q ? src_slot_q : used_q[IDX_W-1:0];
	assign wdata = {cur_q.source_mac, port_in};

	always_comb begin
		res_next.flood       = ~hit;
		res_next.egress_port = hit ? OUT_PORT_W'(port_out) : '0;
		res_next.frame_class = cur_q.frame_class;
		res_next.class_count = cur_q.class_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			rd_valid_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rd_valid_q <= re;
			done_q     <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						if ((head.learn || head.lookup) && used_q != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_LEARN;
						end
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_LEARN;
				end
				S_LEARN: begin
					if (we && !src_hit_q) begin
						used_q <= used_q + 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q;
		if (rd_valid_q) begin
			if (!src_hit_q && ent_mac == cur_q.source_mac) begin
				src_hit_q  <= 1'b1;
				src_slot_q <= rd_idx_q;
			end
			if (!dst_hit_q && ent_mac == cur_q.dest_mac) begin
				dst_hit_q  <= 1'b1;
				dst_port_q <= ent_port;
			end
		end
		if (state_q == S_SCAN) begin
			idx_q <= idx_q + 1'b1;
		end
		if (pop) begin
			cur_q     <= head;
			idx_q     <= '0;
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end
		if (state_q == S_LEARN) begin
			res_q <= res_next;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`LSF_ASSERT(a_used_bound, used_q <= CNT_W'(TABLE_ENTRIES), "table fill count beyond depth")
	`LSF_ASSERT(a_used_step, used_q == $past(used_q) || used_q == $past(used_q) + 1'b1, "fill count jumped")
	`LSF_ASSERT_NEXT(a_done_after_learn, state_q == S_LEARN, done_q, "no result after learn step")
	`LSF_ASSERT(a_done_source, !done_q || $past(state_q == S_LEARN), "result without learn step")
	`LSF_ASSERT(a_no_write_in_scan, !(we && re), "table write during scan")

endmodule

`default_nettype wire

// File: tb/sv/learning_switch_forward_core_test.sv
// Self-checking bench for learning_switch_forward_core: directed and random frame headers,
// a MAC learning and class counter predictor, and an in-order check of every result.
// Depends on lsf_pkg and the core RTL only.
`default_nettype none

module learning_switch_forward_core_test;
	import lsf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SIZE  = DEF_TABLE_ENTRIES;
	localparam int POOL_SIZE   = 300;
	localparam int RANDOM_REQS = 650;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 40;
	localparam logic [MAC_W-1:0] BCAST_MAC = '1;

	typedef struct {
		logic [MAC_W-1:0]     dest_mac;
		logic [MAC_W-1:0]     source_mac;
		logic [ETYPE_W-1:0]   ether_type;
		logic [IN_PORT_W-1:0] ingress_port;
		int                   gap;
		bit                   drain;
	} hdr_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [MAC_W-1:0]      dest_mac = '0;
	logic [MAC_W-1:0]      source_mac = '0;
	logic [ETYPE_W-1:0]    ether_type = '0;
	logic [IN_PORT_W-1:0]  ingress_port = '0;
	logic                  done;
	logic                  flood;
	logic [OUT_PORT_W-1:0] egress_port;
	logic [CLASS_W-1:0]    frame_class;
	logic [COUNT_W-1:0]    class_count;

	hdr_req_t hdr_pending[$];
	hdr_req_t cur_req;
	result_t  fwd_expected[$];

	logic [MAC_W-1:0]     learned_mac[TABLE_SIZE];
	logic [IN_PORT_W-1:0] learned_port[TABLE_SIZE];
	int                   learned_used = 0;
	logic [COUNT_W-1:0]   class_tally[NUM_CLASSES] = '{default: '0};

	int n_accepted = 0;
	int n_received = 0;
	int idle_cycles = 0;
	int cycle_count = 0;
	int errors = 0;
	int n_forwarded = 0;
	int n_flooded = 0;
	int n_refused = 0;

	logic [MAC_W-1:0] mac_pool[POOL_SIZE];

	learning_switch_forward_core #(
		.TABLE_ENTRIES(TABLE_SIZE),
		.PORT_BITS    (DEF_PORT_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.dest_mac    (dest_mac),
		.source_mac  (source_mac),
		.ether_type  (ether_type),
		.ingress_port(ingress_port),
		.done        (done),
		.flood       (flood),
		.egress_port (egress_port),
		.frame_class (frame_class),
		.class_count (class_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int mac_slot(logic [MAC_W-1:0] mac);
		for (int i = 0; i < learned_used; i++) begin
			if (learned_mac[i] == mac)
				return i;
		end
		return -1;
	endfunction

	function automatic result_t forward_predict(hdr_req_t r);
		result_t            res;
		int                 slot;
		logic [CLASS_W-1:0] cls;
		if (r.ether_type == ETYPE_ARP)
			cls = CLS_ARP;
		else if (r.ether_type == ETYPE_IPV4)
			cls = CLS_IPV4;
		else
			cls = CLS_OTHER;
		class_tally[cls] = class_tally[cls] + 1'b1;
		// learn before the destination lookup
		if (!r.source_mac[GROUP_BIT]) begin
			slot = mac_slot(r.source_mac);
			if (slot >= 0) begin
				learned_port[slot] = r.ingress_port;
			end else if (learned_used < TABLE_SIZE) begin
				learned_mac[learned_used] = r.source_mac;
				learned_port[learned_used] = r.ingress_port;
				learned_used++;
			end else begin
				n_refused++;
			end
		end
		res.flood = 1'b1;
		res.egress_port = '0;
		if (!r.dest_mac[GROUP_BIT]) begin
			slot = mac_slot(r.dest_mac);
			if (slot >= 0) begin
				res.flood = 1'b0;
				res.egress_port = learned_port[slot];
			end
		end
		if (res.flood)
			n_flooded++;
		else
			n_forwarded++;
		res.frame_class = cls;
		res.class_count = class_tally[cls];
		return res;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[MAC_W-1:0];
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch on request %0d: %s", $realtime, n_received, what);
	endtask

	task automatic queue_hdr(logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
			logic [ETYPE_W-1:0] et, logic [IN_PORT_W-1:0] port, int gap, bit drain);
		hdr_req_t r;
		r.dest_mac = dst;
		r.source_mac = src;
		r.ether_type = et;
		r.ingress_port = port;
		r.gap = gap;
		r.drain = drain;
		hdr_pending.push_back(r);
	endtask

	// request driver
	always @(posedge clk) begin : drive
		bit accepted;
		int idle;
		int in_flight;
		if (!arst_n) begin
			start <= 1'b0;
			idle_cycles <= 0;
		end else begin
			accepted = start && !busy;
			in_flight = n_accepted - n_received;
			if (accepted) begin
				fwd_expected.push_back(forward_predict(cur_req));
				n_accepted <= n_accepted + 1;
				in_flight++;
			end
			idle = accepted ? 0 : idle_cycles;
			if (!start || accepted) begin
				if (hdr_pending.size() != 0 && idle >= hdr_pending[0].gap
						&& (!hdr_pending[0].drain || in_flight == 0)) begin
					cur_req = hdr_pending.pop_front();
					dest_mac <= cur_req.dest_mac;
					source_mac <= cur_req.source_mac;
					ether_type <= cur_req.ether_type;
					ingress_port <= cur_req.ingress_port;
					start <= 1'b1;
					idle_cycles <= 0;
				end else begin
					start <= 1'b0;
					idle_cycles <= idle + 1;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n && done) begin
			if (n_received >= n_accepted || fwd_expected.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = fwd_expected.pop_front();
				if (flood !== want.flood)
					report_mismatch($sformatf("flood %0b, want %0b", flood, want.flood));
				if (egress_port !== want.egress_port)
					report_mismatch($sformatf("egress_port %0d, want %0d",
						egress_port, want.egress_port));
				if (frame_class !== want.frame_class)
					report_mismatch($sformatf("frame_class %0d, want %0d",
						frame_class, want.frame_class));
				if (class_count !== want.class_count)
					report_mismatch($sformatf("class_count %0d, want %0d",
						class_count, want.class_count));
			end
			n_received <= n_received + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen",
				cycle_count, n_received, n_accepted);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [MAC_W-1:0]   src;
		logic [MAC_W-1:0]   dst;
		logic [ETYPE_W-1:0] et;
		logic [MAC_W-1:0]   mac_a;
		logic [MAC_W-1:0]   mac_b;
		logic [MAC_W-1:0]   mac_c;
		int                 sel;
		int                 gap;
		int                 burst;
		int                 fresh;

		mac_a = 48'h02_11_22_33_44_55;
		mac_b = 48'h00_00_00_00_00_01;
		mac_c = 48'h12_34_56_78_9a_bc;

		// directed: group and unknown destinations, all classes, swapped EtherTypes,
		// group sources, same source and destination, port overwrite
		queue_hdr(BCAST_MAC, mac_a, ETYPE_ARP, 8'd3, 0, 1'b0);
		queue_hdr(mac_a, mac_b, ETYPE_IPV4, 8'd255, 0, 1'b0);
		queue_hdr(mac_b, mac_a, 16'h0608, 8'd0, 0, 1'b0);
		queue_hdr(mac_a, mac_a, 16'h0008, 8'd7, 2, 1'b0);
		queue_hdr(48'h01_00_5e_00_00_01, mac_b, 16'hffff, 8'd9, 0, 1'b0);
		queue_hdr(mac_b, 48'h01_80_c2_00_00_00, 16'h0000, 8'd9, 0, 1'b0);
		queue_hdr(48'h0, BCAST_MAC, ETYPE_ARP, 8'd200, 1, 1'b0);
		queue_hdr(48'h0, 48'h0, ETYPE_ARP, 8'd128, 0, 1'b0);
		queue_hdr(48'hfe_ff_ff_ff_ff_ff, 48'hfe_ff_ff_ff_ff_ff, ETYPE_IPV4, 8'h55, 0, 1'b1);
		queue_hdr(mac_c, mac_b, ETYPE_ARP, 8'haa, 0, 1'b0);
		queue_hdr(mac_b, mac_c, 16'h86dd, 8'd1, 0, 1'b0);
		queue_hdr(mac_c, mac_a, ETYPE_IPV4, 8'd64, 0, 1'b0);
		queue_hdr(mac_a, 48'hfe_ff_ff_ff_ff_ff, ETYPE_ARP, 8'd2, 0, 1'b0);
		queue_hdr(48'hfe_ff_ff_ff_ff_ff, mac_c, 16'h8100, 8'd254, 30, 1'b1);

		for (int i = 0; i < POOL_SIZE; i++) begin
			mac_pool[i] = rand_mac();
			mac_pool[i][GROUP_BIT] = 1'b0;
		end

		// random: mostly new unicast sources early on, so the table fills and then refuses keys
		burst = 0;
		fresh = 0;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			sel = $urandom_range(0, 15);
			if (sel < 11 && fresh < POOL_SIZE) begin
				src = mac_pool[fresh];
				fresh++;
			end else if (sel < 14 && fresh > 0) begin
				src = mac_pool[$urandom_range(0, fresh - 1)];
			end else if (sel == 14) begin
				src = rand_mac();
				src[GROUP_BIT] = 1'b1;
			end else begin
				src = rand_mac();
			end

			sel = $urandom_range(0, 9);
			case (sel)
				0: dst = BCAST_MAC;
				1: begin
					dst = rand_mac();
					dst[GROUP_BIT] = 1'b1;
				end
				2: dst = rand_mac();
				3: dst = src;
				default: dst = mac_pool[$urandom_range(0, (fresh == 0) ? 0 : fresh - 1)];
			endcase

			sel = $urandom_range(0, 2);
			if (sel == 0)
				et = ETYPE_ARP;
			else if (sel == 1)
				et = ETYPE_IPV4;
			else
				et = ETYPE_W'($urandom_range(0, 16'hffff));

			if (burst > 0) begin
				gap = 0;
				burst--;
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					burst = $urandom_range(10, 30);
				if (sel < 40)
					gap = 0;
				else if (sel < 85)
					gap = $urandom_range(1, 3);
				else if (sel < 95)
					gap = $urandom_range(4, 10);
				else
					gap = $urandom_range(20, 60);
			end

			queue_hdr(dst, src, et, IN_PORT_W'($urandom_range(0, 255)), gap,
				(i % 150) == 75);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (hdr_pending.size() != 0 || start || n_received != n_accepted)
			@(negedge clk);
		repeat (TABLE_SIZE + 20) @(posedge clk);
		if (n_received != n_accepted || fwd_expected.size() != 0)
			report_mismatch("results still outstanding at end of run");

		$display("ran %0d requests: %0d ARP, %0d IPv4, %0d other; %0d forwarded, %0d flooded",
			n_accepted, class_tally[CLS_ARP], class_tally[CLS_IPV4], class_tally[CLS_OTHER],
			n_forwarded, n_flooded);
		$display("table reached %0d of %0d entries; %0d new source keys refused when full",
			learned_used, TABLE_SIZE, n_refused);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: learning_switch_forward_core.f
+incdir+hw/rtl
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_ram.sv
hw/rtl/lsf_front.sv
hw/rtl/lsf_fifo.sv
hw/rtl/lsf_back.sv
hw/rtl/learning_switch_forward_core.sv
tb/sv/learning_switch_forward_core_test.sv
